@@ design/rbdq_pkg.sv @@
// Shared types, codes and constants for the ring buffer deque.
package rbdq_pkg;

  localparam int WORD_W = 64;
  localparam int POS_W = 10;
  localparam int OCC_W = 11;
  localparam int DEF_CAPACITY = 1024;

  localparam logic [WORD_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_READ_AT    = 3'd3,
    OP_PEEK_BACK  = 3'd4,
    OP_PEEK_FRONT = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]        operation;
    logic [WORD_W-1:0] push_word;
    logic [POS_W-1:0]  position;
  } req_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic [1:0]        status;
    logic [OCC_W-1:0]  occupancy;
  } rsp_item_t;

endpackage

@@ design/rbdq_store.sv @@
// Single-port word store with a registered read port.
module rbdq_store import rbdq_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // One access per cycle; read data is registered and appears in the cycle after the request.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ design/ring_buffer_deque_core.sv @@
// Top level of the ring buffer deque: request decode, pointers and result stages.
// Two stages: a taken request waits in the middle stage, and its result is offered from the output register.
// Throughput: one request per cycle while req_stall is low; the single store port does one read or write each.
// A push written in one cycle is visible to a read accepted in the next cycle.
// Reset (rst, synchronous) empties the deque, clears both stages and stalls requests.
// Store contents are not cleared; only written entries are ever read.
module ring_buffer_deque_core import rbdq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int CMPW = (CW > POS_W) ? CW : POS_W
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  // Slot that lies k places after the front, wrapped at the capacity.
  function automatic logic [PW-1:0] slot_at(input logic [PW-1:0] base,
                                            input logic [PW-1:0] k);
    logic [PW:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (PW+1)'(CAPACITY)) begin
      s = s - (PW+1)'(CAPACITY);
    end
    return s[PW-1:0];
  endfunction

  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;

  // Middle stage: waits for the store read data.
  logic              a_valid;
  logic              a_use_mem;
  logic [WORD_W-1:0] a_word;
  logic [1:0]        a_status;
  logic [OCC_W-1:0]  a_occ;

  logic              out_free, a_move, req_accept;
  logic              mem_wr, mem_rd, use_mem;
  logic [PW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] word_next;
  status_t           status_next;
  logic [PW-1:0]     back_off;

  // Handshake: the middle stage advances when the output register is free.
  // No item is taken while reset is held.
  assign out_free   = !rsp_valid || !rsp_stall;
  assign a_move     = a_valid && out_free;
  assign req_stall  = rst || (a_valid && !out_free);
  assign req_accept = req_valid && !req_stall;

  assign back_off = PW'(count - CW'(1));

  // Decode the request against the current front pointer and count.
  always_comb begin
    front_next  = front;
    count_next  = count;
    word_next   = '0;
    status_next = ST_OK;
    use_mem     = 1'b0;
    mem_wr      = 1'b0;
    mem_addr    = front;
    case (req.operation)
      OP_PUSH_BACK: begin
        if (count >= CW'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          mem_wr     = 1'b1;
          mem_addr   = slot_at(front, PW'(count));
          count_next = count + CW'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_READ_AT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
        if (count == '0) begin
          word_next   = QUIET_NAN;
          status_next = ST_EMPTY;
        end else begin
          use_mem = 1'b1;
          case (req.operation)
            OP_POP_BACK: begin
              mem_addr   = slot_at(front, back_off);
              count_next = count - CW'(1);
            end
            OP_POP_FRONT: begin
              front_next = slot_at(front, PW'(1));
              count_next = count - CW'(1);
            end
            OP_READ_AT: begin
              if (CMPW'(req.position) >= CMPW'(count)) begin
                use_mem     = 1'b0;
                word_next   = QUIET_NAN;
                status_next = ST_RANGE;
              end else begin
                mem_addr = slot_at(front, PW'(req.position));
              end
            end
            OP_PEEK_BACK: begin
              mem_addr = slot_at(front, back_off);
            end
            default: begin
              mem_addr = front;
            end
          endcase
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign mem_rd = req_accept && use_mem;

  rbdq_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (req_accept && mem_wr),
    .rd_en  (mem_rd),
    .addr   (mem_addr),
    .wr_data(req.push_word),
    .rd_data(mem_rdata)
  );

  // Pointer and count update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (req_accept) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Middle stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  // Middle stage payload.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      a_use_mem <= use_mem;
      a_word    <= word_next;
      a_status  <= status_next;
      a_occ     <= OCC_W'(count_next);
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= a_valid;
    end
  end

  // Output register payload: store data replaces the word for real reads.
  always_ff @(posedge clk) begin
    if (a_move) begin
      rsp.read_word <= a_use_mem ? mem_rdata : a_word;
      rsp.status    <= a_status;
      rsp.occupancy <= a_occ;
    end
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("deque count exceeds capacity");

  // Read data waiting in the middle stage is not overwritten while held.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_use_mem && !out_free) |=> $stable(mem_rdata))
    else $error("store read data changed while held");

  // A request other than a push on an empty deque leaves it empty.
  assert property (@(posedge clk) disable iff (rst)
    (req_accept && count == '0 && req.operation != OP_PUSH_BACK) |=> count == '0)
    else $error("empty deque changed by a non-push request");

  // A push on a full deque is refused.
  assert property (@(posedge clk) disable iff (rst)
    (req_accept && count == CW'(CAPACITY) && req.operation == OP_PUSH_BACK)
    |=> count == CW'(CAPACITY))
    else $error("push accepted on a full deque");

endmodule
